@@ rtl/n2w_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n2w_pkg
// Shared types, codes and microcode layout for the number-to-word-token block.
// ----------------------------------------------------------------------------
package n2w_pkg;

  // value width and derived sizes
  localparam int VALUE_BITS  = 31;
  localparam int DIGIT_COUNT = 10;
  localparam int DIGIT_BITS  = 4;
  localparam int BCD_BITS    = DIGIT_COUNT * DIGIT_BITS;
  localparam int GROUP_BITS  = 3 * DIGIT_BITS;
  localparam int PAD_BITS    = 4 * GROUP_BITS - BCD_BITS;
  localparam int CNT_BITS    = $clog2(VALUE_BITS);
  localparam int PC_BITS     = 4;
  localparam int CODE_BITS   = 5;

  // word codes
  localparam logic [CODE_BITS-1:0] CODE_NONE       = 5'd0;
  localparam logic [CODE_BITS-1:0] CODE_TEEN_BASE  = 5'd10;
  localparam logic [CODE_BITS-1:0] CODE_TENS_BASE  = 5'd18;
  localparam logic [CODE_BITS-1:0] CODE_HUNDRED    = 5'd28;
  localparam logic [CODE_BITS-1:0] CODE_PLACE_BASE = 5'd28;

  // group index of the billions group
  localparam logic [1:0] GROUP_TOP = 2'd3;

  // microprogram step addresses
  localparam logic [PC_BITS-1:0] STEP_CONVERT = 4'd0;
  localparam logic [PC_BITS-1:0] STEP_GROUP   = 4'd1;
  localparam logic [PC_BITS-1:0] STEP_HUND    = 4'd2;
  localparam logic [PC_BITS-1:0] STEP_HUNDRED = 4'd3;
  localparam logic [PC_BITS-1:0] STEP_TEEN    = 4'd4;
  localparam logic [PC_BITS-1:0] STEP_TENS    = 4'd5;
  localparam logic [PC_BITS-1:0] STEP_ONES    = 4'd6;
  localparam logic [PC_BITS-1:0] STEP_PLACE   = 4'd7;
  localparam logic [PC_BITS-1:0] STEP_NEXT    = 4'd8;
  localparam logic [PC_BITS-1:0] STEP_FINISH  = 4'd9;

  // datapath operations
  typedef enum logic [1:0] {
    OP_NOP,
    OP_SHIFT,
    OP_NEXT_GROUP,
    OP_FINISH
  } op_t;

  // token source select
  typedef enum logic [2:0] {
    SEL_HUND,
    SEL_HUNDRED,
    SEL_TEEN,
    SEL_TENS,
    SEL_ONES,
    SEL_PLACE
  } emit_sel_t;

  // branch and emit conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_CNT_NZ,
    C_GRP_ZERO,
    C_HUND_NZ,
    C_HUND_Z,
    C_TENS_ONE,
    C_TENS_NZ,
    C_ONES_NZ,
    C_GROUP_NZ
  } cond_t;

  // one microcode word
  typedef struct packed {
    op_t                op;
    emit_sel_t          sel;
    cond_t              emit_cond;
    cond_t              jump_cond;
    logic [PC_BITS-1:0] target;
  } ucode_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic cnt_nz;
    logic grp_zero;
    logic hund_nz;
    logic tens_one;
    logic tens_nz;
    logic ones_nz;
    logic group_nz;
  } flags_t;

  // sequencer commands to the datapath
  typedef struct packed {
    logic      load;
    op_t       op;
    logic      emit;
    emit_sel_t sel;
  } dp_ctrl_t;

endpackage

@@ rtl/number_to_word_tokens.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// number_to_word_tokens
// Spells a non-negative integer as English word codes, most significant first.
// ----------------------------------------------------------------------------
// Usage:
//   Drive value and pulse start; the transaction is taken at a clock edge
//   where start is high and busy is low. busy then stays high until the
//   value has been fully spelled.
//   Results come out on word_code/last, each valid for exactly one cycle
//   while strobe is high; last marks the final token of the value. A zero
//   value yields a single token with code zero. The receiver cannot stall:
//   every strobe cycle is a delivered transaction.
//   Timing: shift-and-add-3 conversion, one shift per value bit, then the
//   microprogram walks four groups at one step per cycle, only the group
//   and next steps for an all-zero group and all steps from group to next
//   for a full one, plus one finish step. The last token appears in the
//   first cycle with busy low. A new value may be started in that cycle.
//   Reset (rst, synchronous) returns the sequencer to idle and drops any
//   token in flight.
// ----------------------------------------------------------------------------
module number_to_word_tokens (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [n2w_pkg::VALUE_BITS-1:0] value,
  output logic                           strobe,
  output logic [n2w_pkg::CODE_BITS-1:0]  word_code,
  output logic                           last
);
  import n2w_pkg::*;

  flags_t   flags;
  dp_ctrl_t ctrl;

  n2w_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .flags (flags),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  n2w_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .ctrl      (ctrl),
    .flags     (flags),
    .strobe    (strobe),
    .word_code (word_code),
    .last      (last)
  );

endmodule

@@ rtl/n2w_ucode_rom.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n2w_ucode_rom
// Read-only control store: one microcode word per sequencer step.
// ----------------------------------------------------------------------------
module n2w_ucode_rom (
  input  logic [n2w_pkg::PC_BITS-1:0] addr,
  output n2w_pkg::ucode_t             word
);
  import n2w_pkg::*;

  // program: convert, then per group hundreds, tens/teen, ones, place word
  always_comb begin
    unique case (addr)
      STEP_CONVERT: word = '{OP_SHIFT,      SEL_HUND,    C_NEVER,    C_CNT_NZ,   STEP_CONVERT};
      STEP_GROUP:   word = '{OP_NOP,        SEL_HUND,    C_NEVER,    C_GRP_ZERO, STEP_NEXT};
      STEP_HUND:    word = '{OP_NOP,        SEL_HUND,    C_HUND_NZ,  C_HUND_Z,   STEP_TEEN};
      STEP_HUNDRED: word = '{OP_NOP,        SEL_HUNDRED, C_ALWAYS,   C_NEVER,    STEP_TEEN};
      STEP_TEEN:    word = '{OP_NOP,        SEL_TEEN,    C_TENS_ONE, C_TENS_ONE, STEP_PLACE};
      STEP_TENS:    word = '{OP_NOP,        SEL_TENS,    C_TENS_NZ,  C_NEVER,    STEP_ONES};
      STEP_ONES:    word = '{OP_NOP,        SEL_ONES,    C_ONES_NZ,  C_NEVER,    STEP_PLACE};
      STEP_PLACE:   word = '{OP_NOP,        SEL_PLACE,   C_GROUP_NZ, C_NEVER,    STEP_NEXT};
      STEP_NEXT:    word = '{OP_NEXT_GROUP, SEL_HUND,    C_NEVER,    C_GROUP_NZ, STEP_GROUP};
      STEP_FINISH:  word = '{OP_FINISH,     SEL_HUND,    C_NEVER,    C_NEVER,    STEP_CONVERT};
      default:      word = '{OP_FINISH,     SEL_HUND,    C_NEVER,    C_NEVER,    STEP_CONVERT};
    endcase
  end

endmodule

@@ rtl/n2w_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n2w_sequencer
// Step counter with conditional jumps; decodes microcode into datapath commands.
// ----------------------------------------------------------------------------
module n2w_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  n2w_pkg::flags_t   flags,
  output logic              busy,
  output n2w_pkg::dp_ctrl_t ctrl
);
  import n2w_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t             state, state_next;
  logic [PC_BITS-1:0] pc, pc_next;
  ucode_t             uword;
  logic               running;
  logic               emit_ok;
  logic               jump_ok;

  function automatic logic cond_true(input cond_t c, input flags_t f);
    logic r;
    begin
      unique case (c)
        C_NEVER:    r = 1'b0;
        C_ALWAYS:   r = 1'b1;
        C_CNT_NZ:   r = f.cnt_nz;
        C_GRP_ZERO: r = f.grp_zero;
        C_HUND_NZ:  r = f.hund_nz;
        C_HUND_Z:   r = !f.hund_nz;
        C_TENS_ONE: r = f.tens_one;
        C_TENS_NZ:  r = f.tens_nz;
        C_ONES_NZ:  r = f.ones_nz;
        C_GROUP_NZ: r = f.group_nz;
        default:    r = 1'b0;
      endcase
      return r;
    end
  endfunction

  n2w_ucode_rom u_rom (
    .addr (pc),
    .word (uword)
  );

  assign running = (state == ST_RUN);
  assign busy    = running;
  assign emit_ok = cond_true(uword.emit_cond, flags);
  assign jump_ok = cond_true(uword.jump_cond, flags);

  // commands to the datapath
  always_comb begin
    ctrl.load = start && !running;
    ctrl.op   = running ? uword.op : OP_NOP;
    ctrl.emit = running && emit_ok;
    ctrl.sel  = uword.sel;
  end

  // next step and run state
  always_comb begin
    state_next = state;
    pc_next    = pc;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_RUN;
          pc_next    = STEP_CONVERT;
        end
      end
      ST_RUN: begin
        if (uword.op == OP_FINISH) begin
          state_next = ST_IDLE;
        end else if (jump_ok) begin
          pc_next = uword.target;
        end else begin
          pc_next = pc + 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc    <= STEP_CONVERT;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
  end

endmodule

@@ rtl/n2w_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n2w_datapath
// Shift-and-add-3 binary to decimal conversion, group digit select and
// token output with one token of lookahead for the last flag.
// ----------------------------------------------------------------------------
module n2w_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [n2w_pkg::VALUE_BITS-1:0] value,
  input  n2w_pkg::dp_ctrl_t             ctrl,
  output n2w_pkg::flags_t               flags,
  output logic                          strobe,
  output logic [n2w_pkg::CODE_BITS-1:0] word_code,
  output logic                          last
);
  import n2w_pkg::*;

  logic [VALUE_BITS-1:0]   sh;
  logic [BCD_BITS-1:0]     bcd;
  logic [BCD_BITS-1:0]     bcd_adj;
  logic [CNT_BITS-1:0]     cnt;
  logic [1:0]              group;
  logic [4*GROUP_BITS-1:0] digits_pad;
  logic [GROUP_BITS-1:0]   grp;
  logic [DIGIT_BITS-1:0]   ones, tens, hund;
  logic [CODE_BITS-1:0]    new_code;
  logic [CODE_BITS-1:0]    pend_code;
  logic                    pend_valid;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      if (bcd[i*DIGIT_BITS +: DIGIT_BITS] >= 4'd5) begin
        bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd[i*DIGIT_BITS +: DIGIT_BITS] + 4'd3;
      end else begin
        bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd[i*DIGIT_BITS +: DIGIT_BITS];
      end
    end
  end

  // digits of the current three-digit group
  assign digits_pad = {{PAD_BITS{1'b0}}, bcd};
  assign grp        = digits_pad[group*GROUP_BITS +: GROUP_BITS];
  assign ones       = grp[DIGIT_BITS-1:0];
  assign tens       = grp[2*DIGIT_BITS-1:DIGIT_BITS];
  assign hund       = grp[3*DIGIT_BITS-1:2*DIGIT_BITS];

  always_comb begin
    flags.cnt_nz   = (cnt != '0);
    flags.grp_zero = (grp == '0);
    flags.hund_nz  = (hund != '0);
    flags.tens_one = (tens == 4'd1);
    flags.tens_nz  = (tens != '0);
    flags.ones_nz  = (ones != '0);
    flags.group_nz = (group != 2'd0);
  end

  // token code for the selected source
  always_comb begin
    case (ctrl.sel)
      SEL_HUND:    new_code = {1'b0, hund};
      SEL_HUNDRED: new_code = CODE_HUNDRED;
      SEL_TEEN:    new_code = CODE_TEEN_BASE + {1'b0, ones};
      SEL_TENS:    new_code = CODE_TENS_BASE + {1'b0, tens};
      SEL_ONES:    new_code = {1'b0, ones};
      SEL_PLACE:   new_code = CODE_PLACE_BASE + {3'b000, group};
      default:     new_code = CODE_NONE;
    endcase
  end

  // conversion registers and group index
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sh    <= value;
      bcd   <= '0;
      cnt   <= CNT_BITS'(VALUE_BITS - 1);
      group <= GROUP_TOP;
    end else begin
      case (ctrl.op)
        OP_SHIFT: begin
          bcd <= {bcd_adj[BCD_BITS-2:0], sh[VALUE_BITS-1]};
          sh  <= {sh[VALUE_BITS-2:0], 1'b0};
          cnt <= cnt - 1'b1;
        end
        OP_NEXT_GROUP: group <= group - 1'b1;
        default: ;
      endcase
    end
  end

  // held token, released when the next one arrives or at finish
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      if (ctrl.load) begin
        pend_valid <= 1'b0;
        strobe     <= 1'b0;
      end else if (ctrl.emit) begin
        pend_valid <= 1'b1;
        strobe     <= pend_valid;
      end else if (ctrl.op == OP_FINISH) begin
        pend_valid <= 1'b0;
        strobe     <= 1'b1;
      end else begin
        strobe     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      pend_code <= new_code;
      word_code <= pend_code;
      last      <= 1'b0;
    end else if (ctrl.op == OP_FINISH) begin
      word_code <= pend_valid ? pend_code : CODE_NONE;
      last      <= 1'b1;
    end
  end

endmodule

@@ rtl/n2w_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n2w_checker
// Port-level checks on the token output of number_to_word_tokens.
// ----------------------------------------------------------------------------
module n2w_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          strobe,
  input logic [n2w_pkg::CODE_BITS-1:0] word_code,
  input logic                          last
);
  import n2w_pkg::*;

  // no token right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !strobe)
    else $error("token strobe right after reset");

  // accepted transaction makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after accepted start");

  // final token only once the block is free again
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("last token while still busy");

  // inner tokens only while the value is being spelled
  a_inner_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("non-final token while idle");

  // empty code stands only as the sole token of a zero value
  a_none_last: assert property (@(posedge clk) disable iff (rst)
    strobe && (word_code == CODE_NONE) |-> last)
    else $error("empty code not marked last");

endmodule

bind number_to_word_tokens n2w_checker u_n2w_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .strobe    (strobe),
  .word_code (word_code),
  .last      (last)
);
